>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the navigation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge, skipped while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/core/oan_pkg.sv
// Types, codes and helpers of the obstacle-avoidance navigation block.
`default_nettype none

package oan_pkg;

  localparam int OAN_FIFO_DEPTH = 4;

  localparam int DIST_W   = 10;
  localparam int BUMP_W   = 4;
  localparam int DUTY_W   = 8;
  localparam int HOLD_W   = 10;
  localparam int CFG_W    = 10;
  localparam int CFG_A_W  = 3;

  localparam logic [DUTY_W-1:0] DUTY_MIN = 8'd80;
  localparam logic [DUTY_W-1:0] DUTY_MID = 8'd160;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
  localparam logic [HOLD_W-1:0] HOLD_TURN = 10'd800;
  localparam logic [HOLD_W-1:0] HOLD_NONE = 10'd0;

  localparam logic [1:0] SPEED_MIN = 2'd1;
  localparam logic [1:0] SPEED_MID = 2'd2;
  localparam logic [1:0] DIR_PREF_RIGHT = 2'd1;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_SPEED_LEVEL  = 3'd0,
    CFG_DIR_PREF     = 3'd1,
    CFG_FRONT_LIMIT  = 3'd2,
    CFG_SIDE_CLEAR   = 3'd3,
    CFG_SIDE_NEAR    = 3'd4,
    CFG_SIDE_RELEASE = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    NAV_CRUISE     = 3'd0,
    NAV_OBST_LEFT  = 3'd1,
    NAV_OBST_RIGHT = 3'd2,
    NAV_PICK_SIDE  = 3'd3,
    NAV_TURN_AROUND = 3'd4,
    NAV_SKIP_LEFT  = 3'd5,
    NAV_SKIP_RIGHT = 3'd6
  } nav_state_t;

  typedef enum logic [1:0] {
    ACT_FWD    = 2'd0,
    ACT_LEFT   = 2'd1,
    ACT_RIGHT  = 2'd2,
    ACT_AROUND = 2'd3
  } motor_act_t;

  typedef enum logic [1:0] {
    REQ_NONE   = 2'd0,
    REQ_RIGHT  = 2'd1,
    REQ_LEFT   = 2'd2,
    REQ_AROUND = 2'd3
  } bump_req_t;

  typedef struct packed {
    logic [1:0]        speed_level;
    logic [1:0]        direction_pref;
    logic [DIST_W-1:0] front_limit;
    logic [DIST_W-1:0] side_clear_limit;
    logic [DIST_W-1:0] side_near_limit;
    logic [DIST_W-1:0] side_release_limit;
  } oan_cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] front_distance;
    logic [DIST_W-1:0] left_distance;
    logic [DIST_W-1:0] right_distance;
    logic [BUMP_W-1:0] bumper_hits;
    logic              front_event;
  } oan_item_t;

  typedef struct packed {
    motor_act_t        motor_action;
    logic [DUTY_W-1:0] motor_duty;
    logic [HOLD_W-1:0] hold_ms;
    nav_state_t        nav_state_after;
    logic              last_result;
  } oan_res_t;

  // Decision of one tick: up to two words plus the state to keep.
  typedef struct packed {
    oan_res_t   res_first;
    oan_res_t   res_second;
    logic [1:0] res_cnt;
    nav_state_t state_nxt;
  } oan_step_t;

  function automatic logic [DUTY_W-1:0] oan_duty(input logic [1:0] speed);
    logic [DUTY_W-1:0] duty;
    case (speed)
      SPEED_MIN: duty = DUTY_MIN;
      SPEED_MID: duty = DUTY_MID;
      default:   duty = DUTY_MAX;
    endcase
    return duty;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/oan_nav.sv
// Navigation decision for one tick: bumper resolution, state step, result words.
`default_nettype none

module oan_nav
  import oan_pkg::*;
(
  input  oan_item_t  item,
  input  oan_cfg_t   cfg,
  input  nav_state_t nav_state,
  output oan_step_t  step
);

  bump_req_t         req;
  nav_state_t        st;
  logic              bump_vld;
  motor_act_t        bump_act;
  logic              st_vld;
  motor_act_t        st_act;
  logic              front_blk;
  logic              left_clr;
  logic              right_clr;
  logic [DUTY_W-1:0] duty;
  oan_res_t          bump_res;
  oan_res_t          st_res;

  assign duty      = oan_duty(cfg.speed_level);
  assign front_blk = item.front_distance > cfg.front_limit;
  assign left_clr  = item.left_distance < cfg.side_clear_limit;
  assign right_clr = item.right_distance < cfg.side_clear_limit;

  always_comb begin
    // interrupt order, last write wins
    req = REQ_NONE;
    if (item.front_event)    req = REQ_AROUND;
    if (item.bumper_hits[0]) req = REQ_RIGHT;
    if (item.bumper_hits[1] || item.bumper_hits[2]) req = REQ_AROUND;
    if (item.bumper_hits[3]) req = REQ_LEFT;

    st       = nav_state;
    bump_vld = 1'b0;
    bump_act = ACT_FWD;
    case (req)
      REQ_RIGHT: begin
        bump_vld = 1'b1;
        bump_act = ACT_RIGHT;
        st       = NAV_CRUISE;
      end
      REQ_LEFT: begin
        bump_vld = 1'b1;
        bump_act = ACT_LEFT;
        st       = NAV_CRUISE;
      end
      REQ_AROUND: st = NAV_TURN_AROUND;
      default: ;
    endcase

    st_vld = 1'b0;
    st_act = ACT_FWD;
    case (st)
      NAV_CRUISE: begin
        st_vld = 1'b1;
        st_act = ACT_FWD;
        if (front_blk) begin
          if (left_clr && right_clr) st = NAV_PICK_SIDE;
          else if (right_clr)        st = NAV_OBST_RIGHT;
          else if (left_clr)         st = NAV_OBST_LEFT;
          else                       st = NAV_TURN_AROUND;
        end else if (item.left_distance > cfg.side_near_limit) begin
          st = NAV_SKIP_LEFT;
        end else if (item.right_distance > cfg.side_near_limit) begin
          st = NAV_SKIP_RIGHT;
        end
      end
      NAV_OBST_LEFT: begin
        if (front_blk) begin
          st_vld = 1'b1;
          st_act = ACT_LEFT;
        end else begin
          st = NAV_CRUISE;
        end
      end
      NAV_OBST_RIGHT: begin
        if (front_blk) begin
          st_vld = 1'b1;
          st_act = ACT_RIGHT;
        end else begin
          st = NAV_CRUISE;
        end
      end
      NAV_PICK_SIDE: begin
        st = (cfg.direction_pref == DIR_PREF_RIGHT) ? NAV_OBST_RIGHT : NAV_OBST_LEFT;
      end
      NAV_TURN_AROUND: begin
        st_vld = 1'b1;
        st_act = ACT_AROUND;
        st     = NAV_CRUISE;
      end
      NAV_SKIP_LEFT: begin
        st_vld = 1'b1;
        st_act = ACT_LEFT;
        if (item.left_distance < cfg.side_release_limit) st = NAV_CRUISE;
      end
      NAV_SKIP_RIGHT: begin
        st_vld = 1'b1;
        st_act = ACT_RIGHT;
        if (item.right_distance < cfg.side_release_limit) st = NAV_CRUISE;
      end
      default: st = NAV_CRUISE;
    endcase
  end

  always_comb begin
    bump_res.motor_action    = bump_act;
    bump_res.motor_duty      = duty;
    bump_res.hold_ms         = HOLD_TURN;
    bump_res.nav_state_after = NAV_CRUISE;
    bump_res.last_result     = ~st_vld;

    st_res.motor_action    = st_act;
    st_res.motor_duty      = duty;
    st_res.hold_ms         = HOLD_NONE;
    st_res.nav_state_after = st;
    st_res.last_result     = 1'b1;

    step.res_first  = bump_vld ? bump_res : st_res;
    step.res_second = st_res;
    step.res_cnt    = {1'b0, bump_vld} + {1'b0, st_vld};
    step.state_nxt  = st;
  end

endmodule

`default_nettype wire

>>> rtl/core/obstacle_avoid_nav_fsm_top.sv
// Top level of the obstacle-avoidance navigation block.
//
// One input word per control tick: three IR distance samples, bumper change
// bits and the front infrared event. Each tick yields zero, one or two motor
// command words on the output stream; out_tlast marks the last word of a
// tick. A tick that only moves the state (pick side, leaving a turn) gives
// no word at all.
// Pipeline: input register -> decision logic -> small output queue.
// An accepted word is held in the input register until the decision logic
// writes its result words into the queue, whose oldest word drives out_tdata.
// The input stage takes one word per cycle while the queue has room for two;
// ticks with two words are bounded by the output side at one word per cycle.
// When the receiver stalls, words wait in the queue (FIFO_DEPTH entries)
// and in_tready drops once the input register is full and the queue is
// nearly full; nothing is lost or reordered.
// Reset (rst_n low at a clock edge) empties the queue and the input register,
// returns to cruising and loads the default thresholds and speed.
// Configuration: cfg_we with cfg_addr and cfg_wdata writes one register per
// cycle; only write while the block is idle.
`default_nettype none
`include "assert_macros.svh"

module obstacle_avoid_nav_fsm_top
  import oan_pkg::*;
#(
  parameter int FIFO_DEPTH = OAN_FIFO_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // fields from bit 0: front_distance[9:0], left_distance[9:0],
  // right_distance[9:0], bumper_hits[3:0], front_event, zero pad
  input  wire logic [39:0]        in_tdata,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // fields from bit 0: motor_action[1:0], motor_duty[7:0], hold_ms[9:0],
  // nav_state_after[2:0], zero pad
  output logic [23:0]             out_tdata,
  output logic                    out_tlast,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire logic               cfg_we,
  input  wire logic [CFG_A_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]   cfg_wdata
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_ROOM2 = CNT_W'(FIFO_DEPTH - 2);

  // configuration registers
  oan_cfg_t   cfg_r;

  // input register
  oan_item_t  item_r;
  logic       item_vld_r;

  nav_state_t nav_state_r;
  oan_step_t  step;

  // output queue
  oan_res_t        fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic [PTR_W-1:0] wr_ptr_inc2;
  logic [PTR_W-1:0] rd_ptr_inc;

  logic       proc_fire;
  logic       pop;
  logic [1:0] push_cnt;
  oan_res_t   head;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_level        <= 2'd3;
      cfg_r.direction_pref     <= 2'd2;
      cfg_r.front_limit        <= 10'd600;
      cfg_r.side_clear_limit   <= 10'd512;
      cfg_r.side_near_limit    <= 10'd900;
      cfg_r.side_release_limit <= 10'd700;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SPEED_LEVEL:  cfg_r.speed_level        <= cfg_wdata[1:0];
        CFG_DIR_PREF:     cfg_r.direction_pref     <= cfg_wdata[1:0];
        CFG_FRONT_LIMIT:  cfg_r.front_limit        <= cfg_wdata;
        CFG_SIDE_CLEAR:   cfg_r.side_clear_limit   <= cfg_wdata;
        CFG_SIDE_NEAR:    cfg_r.side_near_limit    <= cfg_wdata;
        CFG_SIDE_RELEASE: cfg_r.side_release_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- input stage ----------------
  // decision runs when the queue can take both possible words
  assign proc_fire = item_vld_r && (cnt_r <= CNT_ROOM2);
  assign in_tready = !item_vld_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.front_distance <= in_tdata[9:0];
      item_r.left_distance  <= in_tdata[19:10];
      item_r.right_distance <= in_tdata[29:20];
      item_r.bumper_hits    <= in_tdata[33:30];
      item_r.front_event    <= in_tdata[34];
    end
  end

  // ---------------- decision ----------------
  oan_nav u_nav (
    .item      (item_r),
    .cfg       (cfg_r),
    .nav_state (nav_state_r),
    .step      (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nav_state_r <= NAV_CRUISE;
    end else if (proc_fire) begin
      nav_state_r <= step.state_nxt;
    end
  end

  // ---------------- output queue ----------------
  assign push_cnt    = proc_fire ? step.res_cnt : 2'd0;
  assign pop         = out_tvalid && out_tready;
  assign wr_ptr_inc  = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign wr_ptr_inc2 = (wr_ptr_inc == PTR_LAST) ? '0 : wr_ptr_inc + 1'b1;
  assign rd_ptr_inc  = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      fifo_mem[wr_ptr_r] <= step.res_first;
    end
    if (push_cnt == 2'd2) begin
      fifo_mem[wr_ptr_inc] <= step.res_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      case (push_cnt)
        2'd1:    wr_ptr_r <= wr_ptr_inc;
        2'd2:    wr_ptr_r <= wr_ptr_inc2;
        default: ;
      endcase
      if (pop) rd_ptr_r <= rd_ptr_inc;
      cnt_r <= cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
    end
  end

  assign head       = fifo_mem[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = head.last_result;
  assign out_tdata  = {1'b0, head.nav_state_after, head.hold_ms, head.motor_duty,
                       head.motor_action};

  // ---------------- checks ----------------
  `ASSERT_RST(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(FIFO_DEPTH), "queue count over depth")
  `ASSERT_RST(a_pop_only, clk, rst_n, (pop && push_cnt == 2'd0) |=> cnt_r == $past(cnt_r) - 1'b1, "queue count did not drop on pop")
  `ASSERT_RST(a_stall_holds, clk, rst_n, !in_tready |-> item_vld_r, "input stalled with empty input register")
  `ASSERT_RST(a_held_turn, clk, rst_n, (out_tvalid && head.hold_ms != HOLD_NONE) |-> ((head.motor_action == ACT_LEFT || head.motor_action == ACT_RIGHT) && head.nav_state_after == NAV_CRUISE), "held word is not a bumper turn")

endmodule

`default_nettype wire
